>>> rtl/smpf_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// smpf_pkg
// Types and codes shared by the middle pair finder chain and its control.
// ----------------------------------------------------------------------------
package smpf_pkg;

	localparam int unsigned VALUE_W = 32;
	localparam int unsigned COUNT_W = 7;
	localparam int unsigned STAT_W  = 2;

	localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
	localparam logic [STAT_W-1:0] ST_TOO_FEW  = 2'd1;
	localparam logic [STAT_W-1:0] ST_OVERFLOW = 2'd2;

	typedef struct packed {
		logic signed [VALUE_W-1:0] value;
		logic                      is_last;
	} smpf_in_t;

	typedef struct packed {
		logic signed [VALUE_W-1:0] lower_middle;
		logic signed [VALUE_W-1:0] upper_middle;
		logic [COUNT_W-1:0]        frame_count;
		logic [STAT_W-1:0]         status;
	} smpf_out_t;

	// per-cycle command broadcast to every cell
	typedef struct packed {
		logic ins;    // insert the broadcast value
		logic shift;  // move every entry one cell toward cell 0
		logic clr;    // drop all entries
	} smpf_ctl_t;

endpackage : smpf_pkg
`default_nettype wire

>>> rtl/smpf_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// smpf_cell
// One slot of the insertion chain: holds an entry, compares it to the
// broadcast value and takes its left neighbor's entry when that one moves up.
// ----------------------------------------------------------------------------
module smpf_cell (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire smpf_pkg::smpf_ctl_t               ctl,
	input  wire logic signed [smpf_pkg::VALUE_W-1:0] new_val,
	input  wire logic signed [smpf_pkg::VALUE_W-1:0] prev_val,
	input  wire logic                              prev_gt,
	input  wire logic                              prev_occ,
	input  wire logic signed [smpf_pkg::VALUE_W-1:0] next_val,
	output logic signed [smpf_pkg::VALUE_W-1:0]      val,
	output logic                                   gt,
	output logic                                   occ
);
	import smpf_pkg::*;

	logic signed [VALUE_W-1:0] val_q;
	logic                      occ_q;
	logic                      take;

	assign gt   = occ_q && (val_q > new_val);
	// move when the new value belongs here or below, or this is the first free slot
	assign take = gt || (!occ_q && prev_occ);
	assign val  = val_q;
	assign occ  = occ_q;

	always_ff @(posedge clk) begin
		if (ctl.shift) begin
			val_q <= next_val;
		end else if (ctl.ins && take) begin
			val_q <= prev_gt ? prev_val : new_val;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= 1'b0;
		end else if (ctl.clr) begin
			occ_q <= 1'b0;
		end else if (ctl.ins && take) begin
			occ_q <= 1'b1;
		end
	end

endmodule : smpf_cell
`default_nettype wire

>>> rtl/sorted_middle_pair_finder_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sorted_middle_pair_finder_unit
// Keeps a frame of signed values sorted in a chain of cells and reports the
// entries at positions count/2-1 and count/2 when the frame ends.
// ----------------------------------------------------------------------------
// Throughput: one value per cycle within a frame.
// Frame end: after the last request, the chain shifts its entries down count/2-1
// places (none on error), then loads the result once the output register is free.
// New requests are taken again in the cycle after the result is loaded.
// Reset: arst_n clears the chain occupancy, counters and result valid.
module sorted_middle_pair_finder_unit #(
	parameter int unsigned MAX_ITEMS = 64
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                item_valid,
	output logic                     item_ready,
	input  wire smpf_pkg::smpf_in_t  item,
	output logic                     result_valid,
	input  wire logic                result_ready,
	output smpf_pkg::smpf_out_t      result
);
	import smpf_pkg::*;

	localparam int unsigned CW = $clog2(MAX_ITEMS + 1);

	typedef enum logic [1:0] {
		S_RUN = 2'b01,
		S_FIN = 2'b10
	} state_t;

	state_t                    state_q;
	logic [CW-1:0]             cnt_q;
	logic                      ovf_q;
	logic [CW-1:0]             fin_cnt_q;
	logic [STAT_W-1:0]         stat_q;
	logic [CW-1:0]             shift_q;
	logic                      res_valid_q;
	smpf_out_t                 res_q;

	smpf_ctl_t                 ctl;
	logic signed [VALUE_W-1:0] cval [MAX_ITEMS];
	logic [MAX_ITEMS-1:0]      cgt;
	logic [MAX_ITEMS-1:0]      cocc;

	logic                      acc;
	logic                      full;
	logic [CW-1:0]             cnt_next;
	logic                      ovf_next;
	logic [CW-1:0]             half;
	logic                      load;
	logic [CW+COUNT_W-1:0]     cnt_wide;

	assign item_ready   = (state_q == S_RUN);
	assign acc          = item_valid && item_ready;
	assign full         = cocc[MAX_ITEMS-1];
	assign cnt_next     = full ? cnt_q : cnt_q + CW'(1);
	assign ovf_next     = ovf_q | full;
	assign half         = cnt_next >> 1;
	assign load         = (state_q == S_FIN) && (shift_q == '0)
	                      && (!res_valid_q || result_ready);
	assign cnt_wide     = {{COUNT_W{1'b0}}, fin_cnt_q};

	assign ctl.ins      = acc && !full;
	assign ctl.shift    = (state_q == S_FIN) && (shift_q != '0);
	assign ctl.clr      = load;

	for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
		logic signed [VALUE_W-1:0] pv;
		logic signed [VALUE_W-1:0] nv;
		logic                      pg;
		logic                      po;
		if (i == 0) begin : g_first
			assign pv = item.value;
			assign pg = 1'b0;
			assign po = 1'b1;
		end else begin : g_mid
			assign pv = cval[i-1];
			assign pg = cgt[i-1];
			assign po = cocc[i-1];
		end
		if (i == MAX_ITEMS - 1) begin : g_last
			assign nv = cval[i];
		end else begin : g_inner
			assign nv = cval[i+1];
		end
		smpf_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctl      (ctl),
			.new_val  (item.value),
			.prev_val (pv),
			.prev_gt  (pg),
			.prev_occ (po),
			.next_val (nv),
			.val      (cval[i]),
			.gt       (cgt[i]),
			.occ      (cocc[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_RUN;
			cnt_q     <= '0;
			ovf_q     <= 1'b0;
			shift_q   <= '0;
			fin_cnt_q <= '0;
			stat_q    <= ST_OK;
		end else begin
			case (state_q)
				S_RUN: begin
					if (acc) begin
						if (item.is_last) begin
							state_q   <= S_FIN;
							cnt_q     <= '0;
							ovf_q     <= 1'b0;
							fin_cnt_q <= cnt_next;
							if (ovf_next) begin
								stat_q  <= ST_OVERFLOW;
								shift_q <= '0;
							end else if (cnt_next < CW'(2)) begin
								stat_q  <= ST_TOO_FEW;
								shift_q <= '0;
							end else begin
								stat_q  <= ST_OK;
								shift_q <= half - CW'(1);
							end
						end else begin
							cnt_q <= cnt_next;
							ovf_q <= ovf_next;
						end
					end
				end
				S_FIN: begin
					if (ctl.shift) begin
						shift_q <= shift_q - CW'(1);
					end else if (load) begin
						state_q <= S_RUN;
					end
				end
				default: begin
					state_q <= S_RUN;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (load) begin
			res_valid_q <= 1'b1;
		end else if (result_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q.lower_middle <= (stat_q == ST_OK) ? cval[0] : '0;
			res_q.upper_middle <= (stat_q == ST_OK) ? cval[1] : '0;
			res_q.frame_count  <= cnt_wide[COUNT_W-1:0];
			res_q.status       <= stat_q;
		end
	end

	assign result_valid = res_valid_q;
	assign result       = res_q;

`ifndef SYNTH
	a_occ_prefix: assert property (@(posedge clk) disable iff (!arst_n)
		(cocc & (cocc + MAX_ITEMS'(1))) == '0)
		else $error("chain occupancy has a gap");

	a_cnt_match: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RUN) |-> (32'(cnt_q) == $countones(cocc)))
		else $error("kept count differs from occupied cells");

	a_shift_dec: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.shift |=> (shift_q == $past(shift_q) - CW'(1)))
		else $error("drain counter did not step");

	a_clr_empty: assert property (@(posedge clk) disable iff (!arst_n)
		load |=> (cocc == '0) && res_valid_q)
		else $error("chain not empty after result load");
`endif

endmodule : sorted_middle_pair_finder_unit
`default_nettype wire

>>> sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Streams frames of signed values into the middle pair finder. A local
// sorted-list predictor works out the middle pair, count and status of each
// frame and checks every result as it is taken. Covers short, odd, equal,
// extreme and over-capacity frames, with random gaps and back-pressure.
// ----------------------------------------------------------------------------
module tb;
	import smpf_pkg::*;

	localparam int CAPACITY  = 64;
	localparam int RANDOM_N  = 1850;
	localparam int HOLD_LEN  = 300;
	localparam logic signed [VALUE_W-1:0] VMIN = 32'sh8000_0000;
	localparam logic signed [VALUE_W-1:0] VMAX = 32'sh7fff_ffff;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      item_valid = 1'b0;
	logic      item_ready;
	smpf_in_t  item = '0;
	logic      result_valid;
	logic      result_ready = 1'b0;
	smpf_out_t result;

	sorted_middle_pair_finder_unit #(.MAX_ITEMS(CAPACITY)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_ready(item_ready),
		.item(item),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result(result)
	);

	always #10 clk = ~clk;

	smpf_in_t                    pending_requests[$];
	smpf_out_t                   expected_results[$];
	logic signed [VALUE_W-1:0]   kept_vals[$];
	bit                          dropped = 1'b0;
	logic                        req_taken = 1'b0;
	int                          total_requests = 1;
	int                          sent_count = 0;
	int                          error_count = 0;
	int                          checked_count = 0;
	int                          n_ok = 0, n_too_few = 0, n_overflow = 0;
	int                          hold_left = 0;
	bit                          pressure_done = 1'b0;

	// idle pattern: none, sender, receiver, both, then long receiver hold
	function automatic int phase_now();
		return sent_count * 5 / total_requests;
	endfunction

	function automatic int sender_idle_pct(input int ph);
		return (ph == 1) ? 54 : (ph == 3) ? 24 : 0;
	endfunction

	function automatic int receiver_stall_pct(input int ph);
		return (ph == 2) ? 54 : (ph == 3) ? 24 : 0;
	endfunction

	task automatic add_request(input logic signed [VALUE_W-1:0] v, input bit last);
		smpf_in_t r;
		r.value   = v;
		r.is_last = last;
		pending_requests.push_back(r);
	endtask

	function automatic logic signed [VALUE_W-1:0] pick_value();
		case ($urandom_range(9))
			0: return VMIN;
			1: return VMAX;
			2, 3: return int'($urandom_range(8)) - 4;
			default: return $urandom;
		endcase
	endfunction

	task automatic absorb_request(input smpf_in_t req);
		smpf_out_t r;
		int        pos;
		int        half;
		if (kept_vals.size() >= CAPACITY) begin
			dropped = 1'b1;
		end else begin
			pos = 0;
			while (pos < kept_vals.size() && kept_vals[pos] <= req.value)
				pos++;
			kept_vals.insert(pos, req.value);
		end
		if (req.is_last) begin
			r = '0;
			r.frame_count = COUNT_W'(kept_vals.size());
			if (dropped) begin
				r.status = ST_OVERFLOW;
				n_overflow++;
			end else if (kept_vals.size() < 2) begin
				r.status = ST_TOO_FEW;
				n_too_few++;
			end else begin
				half = kept_vals.size() / 2;
				r.lower_middle = kept_vals[half-1];
				r.upper_middle = kept_vals[half];
				r.status       = ST_OK;
				n_ok++;
			end
			expected_results.push_back(r);
			kept_vals.delete();
			dropped = 1'b0;
		end
	endtask

	task automatic report_field(input string field, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %h, got %h", $time, field, want, got);
			error_count++;
		end
	endtask

	// monitor: sample at the rising edge
	always @(posedge clk) begin
		smpf_out_t want;
		req_taken <= item_valid && item_ready;
		if (arst_n) begin
			if (result_valid && result_ready) begin
				if (expected_results.size() == 0) begin
					$display("%0t: unexpected result, expected none, got %h", $time, result);
					error_count++;
				end else begin
					want = expected_results.pop_front();
					report_field("lower_middle", want.lower_middle, result.lower_middle);
					report_field("upper_middle", want.upper_middle, result.upper_middle);
					report_field("frame_count", 32'(want.frame_count), 32'(result.frame_count));
					report_field("status", 32'(want.status), 32'(result.status));
					checked_count++;
				end
			end
			if (item_valid && item_ready)
				absorb_request(item);
		end
	end

	// request driver
	always @(negedge clk) begin
		if (arst_n && !(item_valid && !req_taken)) begin
			if (pending_requests.size() != 0 &&
					$urandom_range(99) >= sender_idle_pct(phase_now())) begin
				item       <= pending_requests.pop_front();
				item_valid <= 1'b1;
				sent_count++;
			end else begin
				item_valid <= 1'b0;
			end
		end
	end

	// result receiver
	always @(negedge clk) begin
		if (arst_n) begin
			if (phase_now() == 4 && !pressure_done) begin
				pressure_done = 1'b1;
				hold_left     = HOLD_LEN;
			end
			if (hold_left > 0) begin
				hold_left--;
				result_ready <= 1'b0;
			end else begin
				result_ready <= ($urandom_range(99) >= receiver_stall_pct(phase_now()));
			end
		end
	end

	initial begin
		#10_000_000;
		$display("== FAIL ==");
		$finish;
	end

	initial begin
		int len;
		int sel;
		// single values, both extremes
		add_request(VMIN, 1'b1);
		add_request(VMAX, 1'b1);
		// pair in reverse order
		add_request(VMAX, 1'b0);
		add_request(VMIN, 1'b1);
		// odd count, all equal
		add_request(5, 1'b0);
		add_request(5, 1'b0);
		add_request(5, 1'b1);
		add_request(0, 1'b0);
		add_request(-1, 1'b0);
		add_request(VMAX, 1'b0);
		add_request(VMIN, 1'b1);
		add_request(7, 1'b0);
		add_request(-7, 1'b0);
		add_request(3, 1'b0);
		add_request(-3, 1'b0);
		add_request(0, 1'b1);
		while (pending_requests.size() < RANDOM_N + 16) begin
			sel = $urandom_range(99);
			if (sel < 70)
				len = $urandom_range(12, 1);
			else if (sel < 85)
				len = $urandom_range(40, 13);
			else
				len = $urandom_range(CAPACITY + 6, CAPACITY - 4);
			for (int i = 0; i < len; i++)
				add_request(pick_value(), i == len - 1);
		end
		total_requests = pending_requests.size();

		repeat (7) @(negedge clk);
		arst_n = 1'b1;

		while (pending_requests.size() != 0 || item_valid)
			@(posedge clk);
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (100) @(posedge clk);

		$display("Sent %0d requests; checked %0d frame results", sent_count, checked_count);
		$display("Frames: %0d ok, %0d too few, %0d overflow", n_ok, n_too_few, n_overflow);
		if (error_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
